// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers used by the wrench generator top level.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Checked on every rising edge outside of reset.
`define SWTG_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("wrench generator assertion failed");

// Checked on every rising edge, reset included.
`define SWTG_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("wrench generator assertion failed");

`else

`define SWTG_ASSERT(lbl, clk, rst_n, prop)
`define SWTG_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// ----- rtl/swtg_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swtg_pkg
// Shared types, register codes and the quarter-wave sine table function.
// ----------------------------------------------------------------------------
package swtg_pkg;

    localparam int CHANNELS        = 6;
    localparam int PER_GROUP       = CHANNELS / 2;
    localparam int COMP_W          = 20;
    localparam int SINE_BITS_DEF   = 10;
    localparam int SINE_MAG_W      = 15;
    localparam int SINE_W          = SINE_MAG_W + 1;
    localparam int CFG_ADDR_W      = 3;
    localparam int CFG_DATA_W      = 64;
    localparam int LIMIT           = 320000;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    // Denominators (2n)(2n+1) of the Taylor series terms, n = 1..9.
    localparam longint unsigned TAYLOR_DIV [9] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272, 64'd342
    };

    localparam logic [1:0] MODE_CONST  = 2'd0;
    localparam logic [1:0] MODE_PULSE  = 2'd1;
    localparam logic [1:0] MODE_SINE   = 2'd2;
    // The spare mode code; it always gives an invalid, zeroed result.
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam logic [CFG_ADDR_W-1:0] REG_MODE       = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_FORCE_AMP  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_MOMENT_AMP = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_FORCE_BIAS = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_MOMENT_BIAS = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_PULSE_WIN  = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_SINE_STEP  = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_SINE_PHASE = 3'd7;

    typedef logic signed [COMP_W-1:0] t_comp;
    typedef t_comp [CHANNELS-1:0] t_wrench;

    // Sine sample and side flags handed from the phase pipe to the channel pipe.
    typedef struct packed {
        logic signed [SINE_W-1:0] sine;
        logic                     pulse;
        logic                     stamp;
    } t_phase;

    // Entry k of the quarter-wave table: sin(pi/2 * k / 2^bits) in Q0.15.
    // Only evaluated at elaboration to fill the constant table.
    function automatic logic [SINE_MAG_W-1:0] sine_q15(input int k, input int bits);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        longint          q;
        x    = (HALF_PI_Q30 * longint'(k) + (64'd1 << (bits - 1))) >> bits;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        for (int n = 1; n <= 9; n++) begin
            term = ((term * x2) >> 30) / TAYLOR_DIV[n-1];
            if ((n % 2) == 1) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        q = (sum + 64'sd16384) >>> 15;
        if (q > 32767) begin
            q = 32767;
        end
        return q[SINE_MAG_W-1:0];
    endfunction

endpackage

// ----- rtl/swtg_phase.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swtg_phase
// Three-stage phase pipe: phase multiply, quadrant fold, sine table read.
// ----------------------------------------------------------------------------
module swtg_phase #(
    parameter int SINE_TABLE_BITS = swtg_pkg::SINE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic [2:0]            i_en,
    input  logic [31:0]           i_t,
    input  logic                  i_stamp,
    input  logic [30:0]           i_step,
    input  logic [31:0]           i_phase,
    input  logic [31:0]           i_start,
    input  logic [31:0]           i_dur,
    output swtg_pkg::t_phase      o_ph
);

    localparam int TBL_N = 1 << SINE_TABLE_BITS;

    logic [swtg_pkg::SINE_MAG_W-1:0] rom [0:TBL_N];

    for (genvar k = 0; k <= TBL_N; k++) begin : g_rom
        assign rom[k] = swtg_pkg::sine_q15(k, SINE_TABLE_BITS);
    end

    // Stage 1: step * t modulo 2^32 and the pulse window test.
    logic [31:0] w_prod;
    logic [32:0] w_stop;
    logic        w_pulse;
    logic [31:0] r1_prod;
    logic        r1_pulse;
    logic        r1_stamp;

    assign w_prod  = {1'b0, i_step} * i_t;
    assign w_stop  = {1'b0, i_start} + {1'b0, i_dur};
    assign w_pulse = (i_t >= i_start) && ({1'b0, i_t} < w_stop);

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r1_prod  <= w_prod;
            r1_pulse <= w_pulse;
            r1_stamp <= i_stamp;
        end
    end

    // Stage 2: add the phase offset and fold the quadrant into a table index.
    logic [31:0]              w_ph;
    logic [SINE_TABLE_BITS:0] w_p;
    logic [SINE_TABLE_BITS:0] w_tbl_n;
    logic [SINE_TABLE_BITS:0] r2_idx;
    logic                     r2_neg;
    logic                     r2_pulse;
    logic                     r2_stamp;

    assign w_ph    = r1_prod + i_phase;
    assign w_p     = {1'b0, w_ph[29 -: SINE_TABLE_BITS]};
    assign w_tbl_n = {1'b1, {SINE_TABLE_BITS{1'b0}}};

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r2_idx   <= w_ph[30] ? (w_tbl_n - w_p) : w_p;
            r2_neg   <= w_ph[31];
            r2_pulse <= r1_pulse;
            r2_stamp <= r1_stamp;
        end
    end

    // Stage 3: registered table read.
    logic [swtg_pkg::SINE_MAG_W-1:0] r3_mag;
    logic                            r3_neg;
    logic                            r3_pulse;
    logic                            r3_stamp;

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r3_mag   <= rom[r2_idx];
            r3_neg   <= r2_neg;
            r3_pulse <= r2_pulse;
            r3_stamp <= r2_stamp;
        end
    end

    logic signed [swtg_pkg::SINE_W-1:0] w_mag_s;

    assign w_mag_s    = $signed({1'b0, r3_mag});
    assign o_ph.sine  = r3_neg ? -w_mag_s : w_mag_s;
    assign o_ph.pulse = r3_pulse;
    assign o_ph.stamp = r3_stamp;

endmodule

// ----- rtl/swtg_chan.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swtg_chan
// Three-stage channel pipe for all six components: scale, combine, limit.
// ----------------------------------------------------------------------------
module swtg_chan (
    input  logic                  i_clk,
    input  logic [2:0]            i_en,
    input  logic [1:0]            i_mode,
    input  swtg_pkg::t_wrench     i_amp,
    input  swtg_pkg::t_wrench     i_bias,
    input  swtg_pkg::t_phase      i_ph,
    output swtg_pkg::t_wrench     o_wrench,
    output logic                  o_valid_res
);

    localparam int PROD_W = swtg_pkg::COMP_W + swtg_pkg::SINE_W;
    localparam int SUM_W  = swtg_pkg::COMP_W + 2;

    // Stage 4: amplitude times sine.
    logic signed [PROD_W-1:0] r4_prod [swtg_pkg::CHANNELS];
    logic                     r4_pulse;
    logic                     r4_ok;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            for (int i = 0; i < swtg_pkg::CHANNELS; i++) begin
                r4_prod[i] <= i_amp[i] * i_ph.sine;
            end
            r4_pulse <= i_ph.pulse;
            r4_ok    <= i_ph.stamp && (i_mode != swtg_pkg::MODE_UNUSED);
        end
    end

    // Stage 5: round the product and select the mode result.
    logic signed [PROD_W:0]  w_rnd [swtg_pkg::CHANNELS];
    logic signed [SUM_W-1:0] w_val [swtg_pkg::CHANNELS];
    logic signed [SUM_W-1:0] r5_val [swtg_pkg::CHANNELS];
    logic                    r5_ok;

    always_comb begin
        for (int i = 0; i < swtg_pkg::CHANNELS; i++) begin
            w_rnd[i] = (PROD_W+1)'(r4_prod[i]) + (PROD_W+1)'(16384);
            case (i_mode)
                swtg_pkg::MODE_CONST: w_val[i] = SUM_W'(i_amp[i]);
                swtg_pkg::MODE_PULSE: w_val[i] = SUM_W'(i_bias[i])
                    + (r4_pulse ? SUM_W'(i_amp[i]) : SUM_W'(0));
                swtg_pkg::MODE_SINE:  w_val[i] = SUM_W'(i_bias[i])
                    + $signed(w_rnd[i][15 +: SUM_W]);
                default:              w_val[i] = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            for (int i = 0; i < swtg_pkg::CHANNELS; i++) begin
                r5_val[i] <= w_val[i];
            end
            r5_ok <= r4_ok;
        end
    end

    // Stage 6: limit check over all channels; a failed result goes out as zeros.
    logic              w_in_lim [swtg_pkg::CHANNELS];
    logic              w_all_ok;
    swtg_pkg::t_wrench r6_wrench;
    logic              r6_valid_res;

    always_comb begin
        w_all_ok = r5_ok;
        for (int i = 0; i < swtg_pkg::CHANNELS; i++) begin
            w_in_lim[i] = (r5_val[i] <= SUM_W'(swtg_pkg::LIMIT))
                       && (r5_val[i] >= -SUM_W'(swtg_pkg::LIMIT));
            w_all_ok    = w_all_ok && w_in_lim[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            for (int i = 0; i < swtg_pkg::CHANNELS; i++) begin
                r6_wrench[i] <= w_all_ok ? r5_val[i][swtg_pkg::COMP_W-1:0] : '0;
            end
            r6_valid_res <= w_all_ok;
        end
    end

    assign o_wrench    = r6_wrench;
    assign o_valid_res = r6_valid_res;

endmodule

// ----- rtl/six_axis_test_wrench_generator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// six_axis_test_wrench_generator
// Test wrench source: constant, pulse or sine forces and moments per time stamp.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Handshake                       Payload
// s_axis    in   s_axis_tvalid / s_axis_tready   tdata: elapsed_us; tuser: stamp_valid
// m_axis    out  m_axis_tvalid / m_axis_tready   tdata: six components; tuser: valid_res
// cfg       in   i_cfg_we (no wait)              i_cfg_addr, i_cfg_wdata
//
// An accepted request enters the first of six register stages and moves on
// through them to the output register, which it leaves once the sink is ready.
// One request can enter in every cycle while the sink keeps up. Stages:
// phase multiply, quadrant fold, sine table read, amplitude multiply, mode
// select, limit check. A stage moves when it is empty or the next one moves.
// Reset is synchronous, active low, and clears the valid bits and config registers.
//
module six_axis_test_wrench_generator #(
    parameter int SINE_TABLE_BITS = swtg_pkg::SINE_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Input stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [31:0]  s_axis_tdata,   // [31:0] elapsed_us
    input  logic [0:0]   s_axis_tuser,   // [0] stamp_valid
    // Output stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [119:0] m_axis_tdata,   // [19:0] force_x, [39:20] force_y,
                                         // [59:40] force_z, [79:60] moment_x,
                                         // [99:80] moment_y, [119:100] moment_z
    output logic [0:0]   m_axis_tuser,   // [0] valid_res
    // Configuration write port
    input  logic                              i_cfg_we,
    input  logic [swtg_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [swtg_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);

`include "assert_macros.svh"

    localparam int STAGES = 6;
    localparam int GRP_W  = swtg_pkg::PER_GROUP * swtg_pkg::COMP_W;

    // Configuration registers. The user must change them only while the pipe is
    // empty; the block does not enforce this. Every stage reads them directly.
    logic [1:0]       r_mode;
    logic [GRP_W-1:0] r_force_amp;
    logic [GRP_W-1:0] r_moment_amp;
    logic [GRP_W-1:0] r_force_bias;
    logic [GRP_W-1:0] r_moment_bias;
    logic [63:0]      r_pulse_win;
    logic [30:0]      r_sine_step;
    logic [31:0]      r_sine_phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= '0;
            r_force_amp   <= '0;
            r_moment_amp  <= '0;
            r_force_bias  <= '0;
            r_moment_bias <= '0;
            r_pulse_win   <= '0;
            r_sine_step   <= '0;
            r_sine_phase  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                swtg_pkg::REG_MODE:        r_mode        <= i_cfg_wdata[1:0];
                swtg_pkg::REG_FORCE_AMP:   r_force_amp   <= i_cfg_wdata[GRP_W-1:0];
                swtg_pkg::REG_MOMENT_AMP:  r_moment_amp  <= i_cfg_wdata[GRP_W-1:0];
                swtg_pkg::REG_FORCE_BIAS:  r_force_bias  <= i_cfg_wdata[GRP_W-1:0];
                swtg_pkg::REG_MOMENT_BIAS: r_moment_bias <= i_cfg_wdata[GRP_W-1:0];
                swtg_pkg::REG_PULSE_WIN:   r_pulse_win   <= i_cfg_wdata;
                swtg_pkg::REG_SINE_STEP:   r_sine_step   <= i_cfg_wdata[30:0];
                swtg_pkg::REG_SINE_PHASE:  r_sine_phase  <= i_cfg_wdata[31:0];
                default: begin
                end
            endcase
        end
    end

    // Unpack the per-channel amplitudes and offsets: forces first, then moments.
    swtg_pkg::t_wrench w_amp;
    swtg_pkg::t_wrench w_bias;

    for (genvar g = 0; g < swtg_pkg::PER_GROUP; g++) begin : g_unpack
        assign w_amp[g]  = r_force_amp[g*swtg_pkg::COMP_W +: swtg_pkg::COMP_W];
        assign w_bias[g] = r_force_bias[g*swtg_pkg::COMP_W +: swtg_pkg::COMP_W];
        assign w_amp[g+swtg_pkg::PER_GROUP] =
            r_moment_amp[g*swtg_pkg::COMP_W +: swtg_pkg::COMP_W];
        assign w_bias[g+swtg_pkg::PER_GROUP] =
            r_moment_bias[g*swtg_pkg::COMP_W +: swtg_pkg::COMP_W];
    end

    // Stage valid bits and per-stage load enables. A stage loads when it is
    // empty or when the next stage (for the last one, the sink) loads in the same cycle.
    logic [STAGES-1:0] r_vld;
    logic [STAGES-1:0] n_vld;
    logic [STAGES-1:0] w_en;

    always_comb begin
        w_en[STAGES-1] = !r_vld[STAGES-1] || m_axis_tready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
        n_vld = r_vld;
        if (w_en[0]) begin
            n_vld[0] = s_axis_tvalid;
        end
        for (int k = 1; k < STAGES; k++) begin
            if (w_en[k]) begin
                n_vld[k] = r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    swtg_pkg::t_phase w_ph;

    swtg_phase #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_phase (
        .i_clk   (i_clk),
        .i_en    (w_en[2:0]),
        .i_t     (s_axis_tdata),
        .i_stamp (s_axis_tuser[0]),
        .i_step  (r_sine_step),
        .i_phase (r_sine_phase),
        .i_start (r_pulse_win[31:0]),
        .i_dur   (r_pulse_win[63:32]),
        .o_ph    (w_ph)
    );

    swtg_pkg::t_wrench w_wrench;
    logic              w_valid_res;

    swtg_chan u_chan (
        .i_clk       (i_clk),
        .i_en        (w_en[5:3]),
        .i_mode      (r_mode),
        .i_amp       (w_amp),
        .i_bias      (w_bias),
        .i_ph        (w_ph),
        .o_wrench    (w_wrench),
        .o_valid_res (w_valid_res)
    );

    assign s_axis_tready   = w_en[0];
    assign m_axis_tvalid   = r_vld[STAGES-1];
    assign m_axis_tdata    = w_wrench;
    assign m_axis_tuser[0] = w_valid_res;

    // An invalid result carries all-zero components.
    `SWTG_ASSERT(a_invalid_zero, i_clk, i_rst_n,
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == '0))
    // With the output stage empty every stage can move, so the input is open.
    `SWTG_ASSERT(a_empty_ready, i_clk, i_rst_n, !m_axis_tvalid |-> s_axis_tready)
    // An accepted request always occupies the first stage on the next cycle.
    `SWTG_ASSERT(a_accept_fill, i_clk, i_rst_n,
        (s_axis_tvalid && s_axis_tready) |=> r_vld[0])

endmodule
